### rtl/core/ipd_pkg.sv
`default_nettype none
package ipd_pkg;

    // Table geometry
    localparam int ENTRIES    = 1024;
    localparam int INDEX_BITS = 12;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int COUNT_W    = $clog2(ENTRIES + 1);
    localparam int PAIR_W     = 2 * INDEX_BITS;

    // Item opcodes
    localparam logic [1:0] OP_FIND  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_RD_BAD = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]            op;
        logic [INDEX_BITS-1:0] pos_idx;
        logic [INDEX_BITS-1:0] tex_idx;
        logic [SLOT_W-1:0]     slot;
    } ipd_cmd_t;

    // Result item
    typedef struct packed {
        logic [SLOT_W-1:0]     result_slot;
        logic                  was_new;
        logic [1:0]            status;
        logic [INDEX_BITS-1:0] xyz_out;
        logic [INDEX_BITS-1:0] tex_out;
        logic [COUNT_W-1:0]    entry_count;
    } ipd_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic rd_issue;
        logic finish;
    } ipd_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_hit;
        logic scan_end;
    } ipd_sts_t;

endpackage
`default_nettype wire

### rtl/core/ipd_ctrl.sv
`default_nettype none
module ipd_ctrl
    import ipd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic [1:0] op,
    input  wire ipd_sts_t sts,
    output ipd_ctl_t      ctl,
    output logic          busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_RD_ISSUE = 3'd2;
    localparam logic [2:0] S_RD_DATA  = 3'd3;
    localparam logic [2:0] S_SIMPLE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    unique case (op)
                        OP_FIND: state_next = S_SCAN;
                        OP_READ: state_next = S_RD_ISSUE;
                        default: state_next = S_SIMPLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_hit || sts.scan_end)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = S_RD_DATA;
            end
            S_RD_DATA, S_SIMPLE:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

### rtl/core/ipd_datapath.sv
`default_nettype none
module ipd_datapath
    import ipd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ipd_cmd_t cmd,
    input  wire ipd_ctl_t ctl,
    output ipd_sts_t      sts,
    output ipd_rsp_t      rsp,
    output logic          done
);

    // Pair store: {position, texture} per slot
    logic [PAIR_W-1:0] mem [ENTRIES];

    logic [1:0]            op_reg;
    logic [INDEX_BITS-1:0] xyz_reg;
    logic [INDEX_BITS-1:0] tex_reg;
    logic [SLOT_W-1:0]     slot_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] ptr_reg;
    logic               rd_vld_reg;
    logic [SLOT_W-1:0]  rd_addr_reg;
    logic [PAIR_W-1:0]  rd_data_reg;

    ipd_rsp_t rsp_reg;
    ipd_rsp_t rsp_next;
    logic     done_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic              hit;
    logic              full;

    // Item capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= cmd.op;
            xyz_reg  <= cmd.pos_idx;
            tex_reg  <= cmd.tex_idx;
            slot_reg <= cmd.slot;
        end
    end

    // Scan: one read issued and one compare per cycle
    assign rd_en   = ctl.rd_issue || (ctl.scan_step && (ptr_reg != count_reg));
    assign rd_addr = ctl.rd_issue ? slot_reg : ptr_reg[SLOT_W-1:0];
    assign hit     = rd_vld_reg && (rd_data_reg == {xyz_reg, tex_reg});
    assign full    = (count_reg == COUNT_W'(ENTRIES));

    assign sts.scan_hit = hit;
    assign sts.scan_end = (ptr_reg == count_reg) && !hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (ctl.scan_step)
        begin
            rd_vld_reg <= (ptr_reg != count_reg);
            if (ptr_reg != count_reg)
            begin
                ptr_reg <= ptr_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_step)
        begin
            rd_addr_reg <= ptr_reg[SLOT_W-1:0];
        end
    end

    // Memory: one write port, one registered read port
    assign wr_en = ctl.finish && (op_reg == OP_FIND) && !hit && !full;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[SLOT_W-1:0]] <= {xyz_reg, tex_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result and count update
    always_comb
    begin
        count_next = count_reg;
        rsp_next   = '0;
        unique case (op_reg)
            OP_FIND:
            begin
                if (hit)
                begin
                    rsp_next.result_slot = rd_addr_reg;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.result_slot = count_reg[SLOT_W-1:0];
                    rsp_next.was_new     = 1'b1;
                    count_next           = count_reg + COUNT_W'(1);
                end
            end
            OP_READ:
            begin
                rsp_next.result_slot = slot_reg;
                if (COUNT_W'(slot_reg) < count_reg)
                begin
                    rsp_next.xyz_out = rd_data_reg[PAIR_W-1:INDEX_BITS];
                    rsp_next.tex_out = rd_data_reg[INDEX_BITS-1:0];
                end
                else
                begin
                    rsp_next.status = ST_RD_BAD;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.entry_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
            if (ctl.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(ENTRIES))
        else $error("entry count above table size");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("scan pointer passed entry count");

    a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.was_new |->
            (rsp_reg.status == ST_OK) &&
            (rsp_reg.entry_count == COUNT_W'(rsp_reg.result_slot) + COUNT_W'(1)))
        else $error("appended slot does not match new count");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish && (op_reg == OP_FIND) |=>
            (count_reg == $past(count_reg)) ||
            (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("find changed count by more than one");

endmodule
`default_nettype wire

### rtl/core/index_pair_dedup_table.sv
`default_nettype none
// Pair interning table. Raise start with an item on cmd while busy is low;
// the item is taken at that edge. Each item gives exactly one result on rsp,
// valid only in the single cycle done is high; the receiver cannot stall it,
// so capture it then. Find-or-insert scans stored pairs in slot order from a
// memory with one write port and one registered read port, one pair per cycle,
// and stops at the first match or after the last stored pair. A read issues
// one memory read and returns the pair at its slot; a clear empties the table.
// The next item may be started in the cycle done is high. Status reports a
// full table on insert and reads at slots not yet written.
module index_pair_dedup_table
    import ipd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ipd_cmd_t cmd,
    output logic          busy,
    output logic          done,
    output ipd_rsp_t      rsp
);

    ipd_ctl_t ctl;
    ipd_sts_t sts;

    ipd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (cmd.op),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    ipd_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp),
        .done  (done)
    );

endmodule
`default_nettype wire
